>>> hdl/assert_macros.svh
// assertion macros for the port-level checker bmf_chk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication, checked only out of reset
`define BMF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked implication, checked during reset too
`define BMF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/bmf_pkg.sv
// constants and types shared by the box mean filter modules
package bmf_pkg;

    localparam int MAX_WINDOW = 7;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int PIXEL_BITS = 8;

    localparam int KMAX       = (MAX_WINDOW - 1) | 1;
    localparam int RING_ROWS  = 2 * MAX_WINDOW;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
    localparam int SLOT_BITS  = $clog2(RING_ROWS);
    localparam int ADDR_BITS  = SLOT_BITS + COL_BITS;
    localparam int DIM_BITS   = 11;
    localparam int KW_BITS    = 3;
    localparam int OFF_BITS   = $clog2(KMAX);
    localparam int HALF_BITS  = $clog2(KMAX / 2 + 1);
    localparam int KK_BITS    = $clog2(KMAX * KMAX + 1);
    localparam int SUM_BITS   = PIXEL_BITS + $clog2(KMAX * KMAX);
    localparam int CNT_BITS   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int POS_BITS   = DIM_BITS + 2;
    localparam int SPOS_BITS  = SLOT_BITS + 2;
    localparam int MEAN_BITS  = 8;

    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = DIM_BITS;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WINDOW = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_idx;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic                start;
        logic [SUM_BITS-1:0] num;
        logic [KK_BITS-1:0]  den;
    } t_div_req;

endpackage

>>> hdl/bmf_ram.sv
// simple dual-port synchronous ram, registered read data
module bmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

>>> hdl/bmf_div.sv
// bit-serial restoring divider for the window sum
module bmf_div
    import bmf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_div_req            i_req,
    output logic                o_done,
    output logic [SUM_BITS-1:0] o_quot
);

    localparam int STEP_BITS = $clog2(SUM_BITS + 1);

    logic [SUM_BITS-1:0]  r_num;
    logic [KK_BITS-1:0]   r_rem;
    logic [KK_BITS-1:0]   r_den;
    logic [STEP_BITS-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [KK_BITS:0]     trial;
    logic                 qbit;

    assign trial = {r_rem, r_num[SUM_BITS-1]};
    assign qbit  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_BITS'(SUM_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in where the numerator bits leave
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_num <= {r_num[SUM_BITS-2:0], qbit};
            r_rem <= qbit ? KK_BITS'(trial - {1'b0, r_den}) : trial[KK_BITS-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

>>> hdl/box_mean_filter.sv
// box mean filter top level: line store ring, window read sequencer and output stage
// Takes one raster-order pixel (or drain slot) at a time and gives at most one mean per
// transaction. A transaction that gives no mean passes S_IDLE and S_CHECK; one that gives a mean
// also passes S_SUM, S_LAST, S_DIV, S_DIVW and S_OUT: the window is read one neighbor per cycle
// through the single read port of the line store ring (2*MAX_WINDOW rows), and the sum is
// divided by k*k in a bit-serial divider of SUM_BITS steps. A stalled result holds the next in S_OUT.
// The line store needs no clearing; no pass follows reset.
module box_mean_filter
    import bmf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [PIXEL_BITS-1:0]    s_tdata,   // pixel
    input  logic                     s_tuser,   // operation
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [MEAN_BITS-1:0]     m_tdata,   // mean
    output logic                     m_tlast,   // frame_end
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_SUM, S_LAST, S_DIV, S_DIVW, S_OUT
    } t_state;

    t_state r_state;

    logic [KW_BITS-1:0]   r_win;
    logic [DIM_BITS-1:0]  r_width;
    logic [DIM_BITS-1:0]  r_height;
    logic [CNT_BITS-1:0]  r_total;
    logic [CNT_BITS-1:0]  r_lead;

    logic [COL_BITS-1:0]  r_icol;
    logic [DIM_BITS-1:0]  r_irow;
    logic [SLOT_BITS-1:0] r_islot;
    logic [CNT_BITS-1:0]  r_received;
    logic [CNT_BITS-1:0]  r_given;
    logic [COL_BITS-1:0]  r_ocol;
    logic [ROW_BITS-1:0]  r_orow;
    logic [SLOT_BITS-1:0] r_oslot;
    logic [OFF_BITS-1:0]  r_roff;
    logic [OFF_BITS-1:0]  r_coff;
    logic                 r_rd_vld;
    logic [SUM_BITS-1:0]  r_sum;
    logic                 r_out_vld;
    logic [MEAN_BITS-1:0] r_mean;
    logic                 r_last;

    logic [KW_BITS-1:0]   k_raw;
    logic [KW_BITS-1:0]   k_eff;
    logic [HALF_BITS-1:0] half;
    logic [KK_BITS-1:0]   kk;
    logic [DIM_BITS-1:0]  w_eff;
    logic [DIM_BITS-1:0]  h_eff;
    logic [OFF_BITS-1:0]  k_last;

    logic                  accept;
    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic signed [POS_BITS-1:0]  rpos;
    logic signed [POS_BITS-1:0]  cpos;
    logic signed [SPOS_BITS-1:0] spos;
    logic [SLOT_BITS-1:0]  rslot;
    logic                  inb;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic [PIXEL_BITS-1:0] rd_data;
    logic                  go;
    logic [CNT_BITS:0]     need;
    t_div_req              div_req;
    logic                  div_done;
    logic [SUM_BITS-1:0]   div_quot;
    logic                  out_free;

    // effective geometry
    always_comb begin
        k_raw  = r_win | KW_BITS'(1);
        k_eff  = (k_raw > KW_BITS'(KMAX)) ? KW_BITS'(KMAX) : k_raw;
        half   = HALF_BITS'(k_eff >> 1);
        kk     = KK_BITS'(k_eff) * KK_BITS'(k_eff);
        k_last = OFF_BITS'(k_eff - 1'b1);
        if (r_width == '0) begin
            w_eff = DIM_BITS'(1);
        end else if (r_width > DIM_BITS'(MAX_WIDTH)) begin
            w_eff = DIM_BITS'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = DIM_BITS'(1);
        end else if (r_height > DIM_BITS'(MAX_HEIGHT)) begin
            h_eff = DIM_BITS'(MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
    end

    assign accept  = s_tvalid && s_tready;
    assign wr_en   = accept && (s_tuser == OP_PIXEL) && (r_irow < h_eff);
    assign wr_addr = {r_islot, r_icol};

    // window neighbor address and bounds
    always_comb begin
        rpos = $signed({{(POS_BITS-ROW_BITS){1'b0}}, r_orow})
             + $signed({{(POS_BITS-OFF_BITS){1'b0}}, r_roff})
             - $signed({{(POS_BITS-HALF_BITS){1'b0}}, half});
        cpos = $signed({{(POS_BITS-COL_BITS){1'b0}}, r_ocol})
             + $signed({{(POS_BITS-OFF_BITS){1'b0}}, r_coff})
             - $signed({{(POS_BITS-HALF_BITS){1'b0}}, half});
        spos = $signed({2'b00, r_oslot})
             + $signed({{(SPOS_BITS-OFF_BITS){1'b0}}, r_roff})
             - $signed({{(SPOS_BITS-HALF_BITS){1'b0}}, half});
        if (spos < 0) begin
            rslot = SLOT_BITS'(spos + SPOS_BITS'(RING_ROWS));
        end else if (spos >= SPOS_BITS'(RING_ROWS)) begin
            rslot = SLOT_BITS'(spos - SPOS_BITS'(RING_ROWS));
        end else begin
            rslot = SLOT_BITS'(spos);
        end
        inb = (rpos >= 0) && (rpos < $signed({2'b00, h_eff}))
           && (cpos >= 0) && (cpos < $signed({2'b00, w_eff}));
        rd_addr = {rslot, cpos[COL_BITS-1:0]};
    end

    assign need = {1'b0, r_given} + {1'b0, r_lead};
    assign go   = (r_received >= r_total) || ({1'b0, r_received} >= need);

    assign div_req.start = (r_state == S_DIV);
    assign div_req.num   = r_sum;
    assign div_req.den   = kk;

    assign out_free = !r_out_vld || m_tready;

    bmf_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (RING_ROWS * MAX_WIDTH),
        .AW    (ADDR_BITS)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (s_tdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    bmf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // window accumulator
    always_ff @(posedge i_clk) begin
        if (r_state == S_CHECK) begin
            r_sum <= '0;
        end else if (r_rd_vld) begin
            r_sum <= r_sum + SUM_BITS'(rd_data);
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= CNT_BITS'(w_eff) * CNT_BITS'(h_eff);
        r_lead  <= CNT_BITS'(half) * CNT_BITS'(w_eff) + CNT_BITS'(half) + CNT_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_win      <= KW_BITS'(3);
            r_width    <= DIM_BITS'(1024);
            r_height   <= DIM_BITS'(1024);
            r_icol     <= '0;
            r_irow     <= '0;
            r_islot    <= '0;
            r_received <= '0;
            r_given    <= '0;
            r_ocol     <= '0;
            r_orow     <= '0;
            r_oslot    <= '0;
            r_roff     <= '0;
            r_coff     <= '0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_last     <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_SUM) && inb;
            if (r_out_vld && m_tready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (wr_en) begin
                            r_received <= r_received + 1'b1;
                            if ({1'b0, r_icol} + 1'b1 >= w_eff) begin
                                r_icol <= '0;
                                r_irow <= r_irow + 1'b1;
                                r_islot <= (r_islot == SLOT_BITS'(RING_ROWS - 1)) ?
                                           '0 : r_islot + 1'b1;
                            end else begin
                                r_icol <= r_icol + 1'b1;
                            end
                        end
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_roff  <= '0;
                    r_coff  <= '0;
                    r_state <= go ? S_SUM : S_IDLE;
                end
                S_SUM: begin
                    if (r_coff == k_last) begin
                        r_coff <= '0;
                        if (r_roff == k_last) begin
                            r_state <= S_LAST;
                        end else begin
                            r_roff <= r_roff + 1'b1;
                        end
                    end else begin
                        r_coff <= r_coff + 1'b1;
                    end
                end
                S_LAST: r_state <= S_DIV;
                S_DIV:  r_state <= S_DIVW;
                S_DIVW: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_vld <= 1'b1;
                        r_mean    <= div_quot[MEAN_BITS-1:0];
                        r_last    <= (r_given == r_total - 1'b1);
                        r_state   <= S_IDLE;
                        if (r_given + 1'b1 >= r_total) begin
                            // frame done, start over
                            r_given    <= '0;
                            r_received <= '0;
                            r_icol     <= '0;
                            r_irow     <= '0;
                            r_islot    <= '0;
                            r_ocol     <= '0;
                            r_orow     <= '0;
                            r_oslot    <= '0;
                        end else begin
                            r_given <= r_given + 1'b1;
                            if ({1'b0, r_ocol} + 1'b1 >= w_eff) begin
                                r_ocol  <= '0;
                                r_orow  <= r_orow + 1'b1;
                                r_oslot <= (r_oslot == SLOT_BITS'(RING_ROWS - 1)) ?
                                           '0 : r_oslot + 1'b1;
                            end else begin
                                r_ocol <= r_ocol + 1'b1;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // a write to a defined register abandons the frame
            if (i_cfg_we && (i_cfg_idx <= CFG_HEIGHT)) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_WINDOW: r_win    <= i_cfg_data[KW_BITS-1:0];
                    CFG_WIDTH:  r_width  <= i_cfg_data;
                    CFG_HEIGHT: r_height <= i_cfg_data;
                    default:    r_win    <= r_win;
                endcase
                r_given    <= '0;
                r_received <= '0;
                r_icol     <= '0;
                r_irow     <= '0;
                r_islot    <= '0;
                r_ocol     <= '0;
                r_orow     <= '0;
                r_oslot    <= '0;
            end
        end
    end

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_out_vld;
    assign m_tdata  = r_mean;
    assign m_tlast  = r_last;

endmodule

>>> hdl/bmf_chk.sv
// port-level checker for the box mean filter, bound to the top level
`include "assert_macros.svh"

module bmf_chk
    import bmf_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [MEAN_BITS-1:0]  m_tdata,
    input logic                  m_tlast
);

    // a stalled result holds
    `BMF_ASSERT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready |=> m_tvalid, "result dropped")
    `BMF_ASSERT(a_out_stable, i_clk, i_rst_n, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")
    // one transaction at a time: busy right after an accept
    `BMF_ASSERT(a_busy, i_clk, i_rst_n, s_tvalid && s_tready |=> !s_tready, "accepted while busy")
    // a mean never shows the cycle after an accept into an empty output
    `BMF_ASSERT(a_no_early, i_clk, i_rst_n, s_tvalid && s_tready && !m_tvalid |=> !m_tvalid, "result too early")
    `BMF_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !m_tvalid, "result out of reset")

endmodule

bind box_mean_filter bmf_chk u_bmf_chk (.*);
